>>> rtl/shtlp_pkg.sv
`default_nettype none
package shtlp_pkg;

   localparam int TABLE_SIZE_DEFAULT = 1024;

   localparam int SYMBOL_CHARS = 6;
   localparam int CHAR_W       = 8;
   localparam int SYM_W        = SYMBOL_CHARS * CHAR_W;
   localparam int ADDR_W       = 16;
   localparam int HASH_W       = 64;

   typedef enum logic {
      FUNC_INSERT = 1'b0,
      FUNC_SEARCH = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      STATUS_DONE = 2'd0,
      STATUS_MISS = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   typedef struct packed {
      func_type          func;
      logic [SYM_W-1:0]  symbol_text;
      logic [ADDR_W-1:0] entry_address;
   } req_type;

   typedef struct packed {
      logic              found;
      logic [ADDR_W-1:0] found_address;
      status_type        status;
   } rsp_type;

   // one table slot as stored in the RAM
   typedef struct packed {
      logic              used;
      logic [SYM_W-1:0]  symbol;
      logic [ADDR_W-1:0] address;
   } entry_type;

   // drop everything from the first zero character on
   function automatic logic [SYM_W-1:0] canonical_sym(input logic [SYM_W-1:0] sym);
      logic [SYM_W-1:0]  res;
      logic              alive;
      logic [CHAR_W-1:0] c;
      res   = '0;
      alive = 1'b1;
      for (int i = 0; i < SYMBOL_CHARS; i++) begin
         c = sym[SYM_W-1-i*CHAR_W -: CHAR_W];
         if (c == '0) begin
            alive = 1'b0;
         end
         if (alive) begin
            res[SYM_W-1-i*CHAR_W -: CHAR_W] = c;
         end
      end
      return res;
   endfunction

endpackage
`default_nettype wire

>>> rtl/symbol_hash_table_linear_probe.sv
// Flow: a request is hashed one character at a time up to the first zero character (max 6),
//   reduced modulo TABLE_SIZE if that is not a power of two, probed, then answered from a register.
// Throughput: one transaction at a time; the probe walk does one slot per cycle on the
//   table RAM's read port, so collisions set the rate.
// Reset: synchronous; afterwards the table is swept empty, one slot per cycle, with
//   req_stall high the whole time.
`default_nettype none
module symbol_hash_table_linear_probe
   import shtlp_pkg::*;
#(
   parameter int TABLE_SIZE = TABLE_SIZE_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int IDX_W   = $clog2(TABLE_SIZE);
   localparam int CNT_W   = $clog2(TABLE_SIZE + 1);
   localparam int ENTRY_W = $bits(entry_type);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_PROBE,
      S_DONE
   } state_type;

   state_type          state_ff;
   logic [IDX_W-1:0]   clr_idx_ff;
   func_type           func_ff;
   logic [SYM_W-1:0]   sym_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic [CNT_W-1:0]   used_cnt_ff;
   logic [IDX_W-1:0]   chk_idx_ff;
   logic [IDX_W-1:0]   probe_cnt_ff;
   rsp_type            res_ff;
   rsp_type            rsp_data_ff;
   logic               rsp_valid_ff;

   logic               req_accept;
   logic               hash_done;
   logic [IDX_W-1:0]   hash_home;
   logic [IDX_W-1:0]   next_idx;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   entry_type          wr_entry;
   logic [IDX_W-1:0]   rd_addr;
   logic [ENTRY_W-1:0] rd_raw;
   entry_type          rd_entry;
   logic               table_full;

   // Only one transaction is in flight and the insert write lands before the
   // response, so a later read of the same slot never races the write.
   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign table_full = (used_cnt_ff == CNT_W'(TABLE_SIZE));

   shtlp_hash #(
      .TABLE_SIZE(TABLE_SIZE)
   ) u_hash (
      .clock    (clock),
      .reset    (reset),
      .start    (req_accept),
      .sym_text (canonical_sym(req_data.symbol_text)),
      .done     (hash_done),
      .home     (hash_home)
   );

   // linear probe wraps from the last slot to slot zero
   assign next_idx = (chk_idx_ff == LAST_IDX) ? '0 : chk_idx_ff + 1'b1;

   // In the probe state the read for the following slot goes out while the
   // current one is checked; an unneeded read is simply dropped.
   assign rd_addr  = (state_ff == S_HASH) ? hash_home : next_idx;
   assign rd_entry = entry_type'(rd_raw);

   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = clr_idx_ff;
      wr_entry = '0;
      if (state_ff == S_CLEAR) begin
         wr_en = 1'b1;
      end else if (state_ff == S_PROBE && func_ff == FUNC_INSERT && !rd_entry.used) begin
         wr_en            = 1'b1;
         wr_addr          = chk_idx_ff;
         wr_entry.used    = 1'b1;
         wr_entry.symbol  = sym_ff;
         wr_entry.address = addr_ff;
      end
   end

   shtlp_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(TABLE_SIZE)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_idx_ff   <= '0;
         used_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // output register drains independently of the engine; in S_DONE the
         // engine itself decides what the register holds next
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_CLEAR: begin
               clr_idx_ff <= clr_idx_ff + 1'b1;
               if (clr_idx_ff == LAST_IDX) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_accept) begin
                  func_ff  <= req_data.func;
                  sym_ff   <= canonical_sym(req_data.symbol_text);
                  addr_ff  <= req_data.entry_address;
                  state_ff <= S_HASH;
               end
            end
            S_HASH: begin
               if (hash_done) begin
                  res_ff.found         <= 1'b0;
                  res_ff.found_address <= '0;
                  res_ff.status        <= STATUS_FULL;
                  chk_idx_ff           <= hash_home;
                  probe_cnt_ff         <= '0;
                  // insert into a full table skips the probe and never writes the RAM
                  if (func_ff == FUNC_INSERT && table_full) begin
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_PROBE;
                  end
               end
            end
            S_PROBE: begin
               if (!rd_entry.used) begin
                  if (func_ff == FUNC_INSERT) begin
                     used_cnt_ff   <= used_cnt_ff + 1'b1;
                     res_ff.status <= STATUS_DONE;
                  end else begin
                     res_ff.status <= STATUS_MISS;
                  end
                  state_ff <= S_DONE;
               end else if (func_ff == FUNC_SEARCH && rd_entry.symbol == sym_ff) begin
                  res_ff.found         <= 1'b1;
                  res_ff.found_address <= rd_entry.address;
                  res_ff.status        <= STATUS_DONE;
                  state_ff             <= S_DONE;
               end else if (probe_cnt_ff == LAST_IDX) begin
                  // every slot seen once: status stays full
                  state_ff <= S_DONE;
               end else begin
                  chk_idx_ff   <= next_idx;
                  probe_cnt_ff <= probe_cnt_ff + 1'b1;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_data_ff  <= res_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

>>> rtl/shtlp_ram.sv
`default_nettype none
module shtlp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

>>> rtl/shtlp_hash.sv
`default_nettype none
module shtlp_hash
   import shtlp_pkg::*;
#(
   parameter int TABLE_SIZE = TABLE_SIZE_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [SYM_W-1:0]              sym_text,
   output logic                               done,
   output logic [$clog2(TABLE_SIZE)-1:0]      home
);

   localparam int  IDX_W     = $clog2(TABLE_SIZE);
   localparam int  REM_W     = IDX_W + 1;
   localparam int  CCNT_W    = $clog2(SYMBOL_CHARS + 1);
   localparam int  DIGIT_W   = 4;
   localparam int  MOD_STEPS = HASH_W / DIGIT_W;
   localparam int  MCNT_W    = $clog2(MOD_STEPS);
   localparam bit  POW2      = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;
   localparam logic [REM_W-1:0] TSIZE = REM_W'(TABLE_SIZE);

   typedef enum logic [1:0] {
      H_IDLE,
      H_CHAR,
      H_MOD
   } hstate_type;

   hstate_type         state_ff;
   logic [SYM_W-1:0]   sym_ff;
   logic [HASH_W-1:0]  h_ff;
   logic [CCNT_W-1:0]  ccnt_ff;
   logic [MCNT_W-1:0]  mcnt_ff;
   logic [IDX_W-1:0]   rem_ff;
   logic [IDX_W-1:0]   rem_in;
   logic [REM_W-1:0]   rem_work;
   logic [CHAR_W-1:0]  cur_char;
   logic [HASH_W-1:0]  h_step;
   logic               char_end;
   logic               done_in;
   logic               done_ff;
   logic [IDX_W-1:0]   home_ff;

   assign cur_char = sym_ff[SYM_W-1 -: CHAR_W];
   // h * 65599 + c
   assign h_step   = HASH_W'(cur_char) + (h_ff << 6) + (h_ff << 16) - h_ff;

   assign char_end = (cur_char == '0) || (ccnt_ff == CCNT_W'(SYMBOL_CHARS));
   // home is ready straight after the last character, or after the last digit
   assign done_in  = (state_ff == H_CHAR && POW2 && char_end) ||
                     (state_ff == H_MOD && mcnt_ff == MCNT_W'(MOD_STEPS - 1));

   // restoring reduction, one hex digit of the hash per cycle
   always_comb begin
      rem_work = REM_W'(rem_ff);
      for (int k = 0; k < DIGIT_W; k++) begin
         rem_work = {rem_work[IDX_W-1:0], h_ff[HASH_W-1-k]};
         if (rem_work >= TSIZE) begin
            rem_work = rem_work - TSIZE;
         end
      end
      rem_in = rem_work[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= done_in;
         case (state_ff)
            H_IDLE: begin
               if (start) begin
                  sym_ff   <= sym_text;
                  h_ff     <= '0;
                  ccnt_ff  <= '0;
                  state_ff <= H_CHAR;
               end
            end
            H_CHAR: begin
               if (char_end) begin
                  if (POW2) begin
                     home_ff  <= h_ff[IDX_W-1:0];
                     state_ff <= H_IDLE;
                  end else begin
                     rem_ff   <= '0;
                     mcnt_ff  <= '0;
                     state_ff <= H_MOD;
                  end
               end else begin
                  h_ff    <= h_step;
                  sym_ff  <= sym_ff << CHAR_W;
                  ccnt_ff <= ccnt_ff + 1'b1;
               end
            end
            H_MOD: begin
               h_ff    <= h_ff << DIGIT_W;
               rem_ff  <= rem_in;
               mcnt_ff <= mcnt_ff + 1'b1;
               if (mcnt_ff == MCNT_W'(MOD_STEPS - 1)) begin
                  home_ff  <= rem_in;
                  state_ff <= H_IDLE;
               end
            end
            default: begin
               state_ff <= H_IDLE;
            end
         endcase
      end
   end

   assign done = done_ff;
   assign home = home_ff;

endmodule
`default_nettype wire
